### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the quaternion unit checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, checked on every rising clock edge
`define QMR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// property holds on every rising clock edge outside reset
`define QMR_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("invariant check failed");

`endif

### src/qmr_pkg.sv
// ----------------------------------------------------------------------------
// qmr_pkg
// shared operation codes and timing constants of the quaternion unit
// ----------------------------------------------------------------------------
package qmr_pkg;

   typedef enum logic {
      KIND_PRODUCT = 1'b0,
      KIND_ROTATE  = 1'b1
   } kind_type;

   // register stages from transaction accept to result strobe
   localparam int LATENCY = 4;

endpackage

### src/quaternion_multiply_and_rotate_unit.sv
// path: the accepting edge loads stage a, then stages b and c, then output register d drives the result
// throughput: one transaction per cycle, busy stays low, no stall on either side
// stages: 16 multipliers, sums with saturation, 9 multipliers, sums with saturation
// reset: synchronous, active high, clears the valid bits of every stage
// ----------------------------------------------------------------------------
// quaternion_multiply_and_rotate_unit
// hamilton product of two quaternions or rotation of a vector by a quaternion,
// signed fixed point, every result saturated to the word range
// ----------------------------------------------------------------------------
module quaternion_multiply_and_rotate_unit import qmr_pkg::*; #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic signed [WORD_WIDTH-1:0] req_a_w,
   input  logic signed [WORD_WIDTH-1:0] req_a_x,
   input  logic signed [WORD_WIDTH-1:0] req_a_y,
   input  logic signed [WORD_WIDTH-1:0] req_a_z,
   input  logic signed [WORD_WIDTH-1:0] req_b_w,
   input  logic signed [WORD_WIDTH-1:0] req_b_x,
   input  logic signed [WORD_WIDTH-1:0] req_b_y,
   input  logic signed [WORD_WIDTH-1:0] req_b_z,
   output logic                         rsp_valid,
   output logic signed [WORD_WIDTH-1:0] rsp_r_w,
   output logic signed [WORD_WIDTH-1:0] rsp_r_x,
   output logic signed [WORD_WIDTH-1:0] rsp_r_y,
   output logic signed [WORD_WIDTH-1:0] rsp_r_z
);

   localparam int W  = WORD_WIDTH;
   localparam int PW = 2 * WORD_WIDTH - FRAC_BITS;
   localparam int SW = PW + 3;
   localparam int NA = 16;
   localparam int NC = 9;

   typedef logic signed [W-1:0]  word_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] sum_type;

   function automatic word_type sat_word(input sum_type v);
      word_type r;
      if (v[SW-1:W-1] == '0 || v[SW-1:W-1] == '1) begin
         r = v[W-1:0];
      end else if (v[SW-1]) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = {1'b0, {(W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic sum_type ext(input prod_type p);
      return SW'(p);
   endfunction

   // stage a: all first level products
   word_type ma [NA];
   word_type mb [NA];
   prod_type pa [NA];

   logic     valid_a_ff;
   kind_type kind_a_ff;
   word_type aw_a_ff, ax_a_ff, ay_a_ff, az_a_ff;
   word_type bx_a_ff, by_a_ff, bz_a_ff;

   // stage b: product results and doubled cross terms
   logic     valid_b_ff;
   kind_type kind_b_ff;
   word_type aw_b_ff, ax_b_ff, ay_b_ff, az_b_ff;
   word_type bx_b_ff, by_b_ff, bz_b_ff;
   word_type qw_b_ff, qx_b_ff, qy_b_ff, qz_b_ff;
   word_type t0_b_ff, t1_b_ff, t2_b_ff;
   word_type qw_b_in, qx_b_in, qy_b_in, qz_b_in;
   word_type t0_b_in, t1_b_in, t2_b_in;

   // stage c: rotation products
   word_type mc_a [NC];
   word_type mc_b [NC];
   prod_type pc [NC];

   logic     valid_c_ff;
   kind_type kind_c_ff;
   word_type bx_c_ff, by_c_ff, bz_c_ff;
   word_type qw_c_ff, qx_c_ff, qy_c_ff, qz_c_ff;

   // stage d: output registers
   logic     rsp_valid_ff;
   word_type rw_ff, rx_ff, ry_ff, rz_ff;
   word_type rw_in, rx_in, ry_in, rz_in;

   assign busy = 1'b0;

   always_comb begin
      ma[0]  = req_a_w; mb[0]  = req_b_w;
      ma[1]  = req_a_x; mb[1]  = req_b_x;
      ma[2]  = req_a_y; mb[2]  = req_b_y;
      ma[3]  = req_a_z; mb[3]  = req_b_z;
      ma[4]  = req_a_w; mb[4]  = req_b_x;
      ma[5]  = req_a_w; mb[5]  = req_b_y;
      ma[6]  = req_a_w; mb[6]  = req_b_z;
      ma[7]  = req_b_w; mb[7]  = req_a_x;
      ma[8]  = req_b_w; mb[8]  = req_a_y;
      ma[9]  = req_b_w; mb[9]  = req_a_z;
      ma[10] = req_a_y; mb[10] = req_b_z;
      ma[11] = req_a_z; mb[11] = req_b_y;
      ma[12] = req_a_z; mb[12] = req_b_x;
      ma[13] = req_a_x; mb[13] = req_b_z;
      ma[14] = req_a_x; mb[14] = req_b_y;
      ma[15] = req_a_y; mb[15] = req_b_x;
   end

   for (genvar g = 0; g < NA; g++) begin : g_mul_a
      qmr_prod #(
         .WORD_WIDTH (WORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_prod (
         .clock (clock),
         .op_a  (ma[g]),
         .op_b  (mb[g]),
         .prod  (pa[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      kind_a_ff <= kind_type'(req_kind);
      aw_a_ff   <= req_a_w;
      ax_a_ff   <= req_a_x;
      ay_a_ff   <= req_a_y;
      az_a_ff   <= req_a_z;
      bx_a_ff   <= req_b_x;
      by_a_ff   <= req_b_y;
      bz_a_ff   <= req_b_z;
   end

   always_comb begin
      sum_type sw, sx, sy, sz, c0, c1, c2;
      c0 = ext(pa[10]) - ext(pa[11]);
      c1 = ext(pa[12]) - ext(pa[13]);
      c2 = ext(pa[14]) - ext(pa[15]);
      sw = ext(pa[0]) - ext(pa[1]) - ext(pa[2]) - ext(pa[3]);
      sx = ext(pa[4]) + ext(pa[7]) + c0;
      sy = ext(pa[5]) + ext(pa[8]) + c1;
      sz = ext(pa[6]) + ext(pa[9]) + c2;
      qw_b_in = sat_word(sw);
      qx_b_in = sat_word(sx);
      qy_b_in = sat_word(sy);
      qz_b_in = sat_word(sz);
      t0_b_in = sat_word(c0 + c0);
      t1_b_in = sat_word(c1 + c1);
      t2_b_in = sat_word(c2 + c2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind_b_ff <= kind_a_ff;
      aw_b_ff   <= aw_a_ff;
      ax_b_ff   <= ax_a_ff;
      ay_b_ff   <= ay_a_ff;
      az_b_ff   <= az_a_ff;
      bx_b_ff   <= bx_a_ff;
      by_b_ff   <= by_a_ff;
      bz_b_ff   <= bz_a_ff;
      qw_b_ff   <= qw_b_in;
      qx_b_ff   <= qx_b_in;
      qy_b_ff   <= qy_b_in;
      qz_b_ff   <= qz_b_in;
      t0_b_ff   <= t0_b_in;
      t1_b_ff   <= t1_b_in;
      t2_b_ff   <= t2_b_in;
   end

   always_comb begin
      mc_a[0] = aw_b_ff; mc_b[0] = t0_b_ff;
      mc_a[1] = aw_b_ff; mc_b[1] = t1_b_ff;
      mc_a[2] = aw_b_ff; mc_b[2] = t2_b_ff;
      mc_a[3] = ay_b_ff; mc_b[3] = t2_b_ff;
      mc_a[4] = az_b_ff; mc_b[4] = t1_b_ff;
      mc_a[5] = az_b_ff; mc_b[5] = t0_b_ff;
      mc_a[6] = ax_b_ff; mc_b[6] = t2_b_ff;
      mc_a[7] = ax_b_ff; mc_b[7] = t1_b_ff;
      mc_a[8] = ay_b_ff; mc_b[8] = t0_b_ff;
   end

   for (genvar g = 0; g < NC; g++) begin : g_mul_c
      qmr_prod #(
         .WORD_WIDTH (WORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_prod (
         .clock (clock),
         .op_a  (mc_a[g]),
         .op_b  (mc_b[g]),
         .prod  (pc[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind_c_ff <= kind_b_ff;
      bx_c_ff   <= bx_b_ff;
      by_c_ff   <= by_b_ff;
      bz_c_ff   <= bz_b_ff;
      qw_c_ff   <= qw_b_ff;
      qx_c_ff   <= qx_b_ff;
      qy_c_ff   <= qy_b_ff;
      qz_c_ff   <= qz_b_ff;
   end

   always_comb begin
      sum_type vx, vy, vz;
      vx = SW'(bx_c_ff) + ext(pc[0]) + ext(pc[3]) - ext(pc[4]);
      vy = SW'(by_c_ff) + ext(pc[1]) + ext(pc[5]) - ext(pc[6]);
      vz = SW'(bz_c_ff) + ext(pc[2]) + ext(pc[7]) - ext(pc[8]);
      if (kind_c_ff == KIND_ROTATE) begin
         rw_in = '0;
         rx_in = sat_word(vx);
         ry_in = sat_word(vy);
         rz_in = sat_word(vz);
      end else begin
         rw_in = qw_c_ff;
         rx_in = qx_c_ff;
         ry_in = qy_c_ff;
         rz_in = qz_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      rw_ff <= rw_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rz_ff <= rz_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_r_w   = rw_ff;
   assign rsp_r_x   = rx_ff;
   assign rsp_r_y   = ry_ff;
   assign rsp_r_z   = rz_ff;

endmodule

### src/qmr_prod.sv
// ----------------------------------------------------------------------------
// qmr_prod
// registered signed fixed point multiplier, product shifted right by the
// fraction width (rounds toward minus infinity)
// ----------------------------------------------------------------------------
module qmr_prod #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                         clock,
   input  logic signed [WORD_WIDTH-1:0]                 op_a,
   input  logic signed [WORD_WIDTH-1:0]                 op_b,
   output logic signed [2*WORD_WIDTH-FRAC_BITS-1:0]     prod
);

   localparam int FULL_WIDTH = 2 * WORD_WIDTH;
   localparam int PROD_WIDTH = FULL_WIDTH - FRAC_BITS;

   logic signed [FULL_WIDTH-1:0] full;
   logic signed [PROD_WIDTH-1:0] prod_in;
   logic signed [PROD_WIDTH-1:0] prod_ff;

   always_comb begin
      full    = FULL_WIDTH'(op_a) * FULL_WIDTH'(op_b);
      prod_in = full[FULL_WIDTH-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### src/qmr_checker.sv
// ----------------------------------------------------------------------------
// qmr_checker
// port level timing and result checks of the quaternion unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qmr_checker import qmr_pkg::*; #(
   parameter int WORD_WIDTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_kind,
   input logic signed [WORD_WIDTH-1:0] req_a_w,
   input logic signed [WORD_WIDTH-1:0] req_a_x,
   input logic signed [WORD_WIDTH-1:0] req_a_y,
   input logic signed [WORD_WIDTH-1:0] req_a_z,
   input logic                         rsp_valid,
   input logic signed [WORD_WIDTH-1:0] rsp_r_w,
   input logic signed [WORD_WIDTH-1:0] rsp_r_x,
   input logic signed [WORD_WIDTH-1:0] rsp_r_y,
   input logic signed [WORD_WIDTH-1:0] rsp_r_z
);

   logic accept;
   logic zero_a;
   logic rot_take;
   logic zero_take;
   logic rsp_zero;

   assign accept    = start & ~busy;
   assign zero_a    = (req_a_w == '0) && (req_a_x == '0) && (req_a_y == '0) && (req_a_z == '0);
   assign rot_take  = accept && (req_kind == KIND_ROTATE);
   assign zero_take = accept && (req_kind == KIND_PRODUCT) && zero_a;
   assign rsp_zero  = (rsp_r_w == '0) && (rsp_r_x == '0) && (rsp_r_y == '0) && (rsp_r_z == '0);

   // every transaction gives a result after the fixed latency
   `QMR_ASSERT_IMPLY(a_result_follows, clock, reset, accept, ##LATENCY rsp_valid)

   // no result without a transaction
   `QMR_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_valid, $past(accept, LATENCY))

   // rotation leaves the real part at zero
   `QMR_ASSERT_IMPLY(a_rotate_real_zero, clock, reset, $past(rot_take, LATENCY), rsp_r_w == '0)

   // product with a zero quaternion a is zero
   `QMR_ASSERT_IMPLY(a_zero_product, clock, reset, $past(zero_take, LATENCY), rsp_zero)

endmodule

bind quaternion_multiply_and_rotate_unit qmr_checker #(
   .WORD_WIDTH (WORD_WIDTH)
) u_qmr_checker (.*);
